// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst is high.
`define SBPK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sbpk assertion failed");

// Checked on every rising edge of clk, reset included.
`define SBPK_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sbpk assertion failed");

`endif

// ===== rtl/sbpk_pkg.sv =====
package sbpk_pkg;

  localparam int BIN_W       = 12;
  localparam int MAG_W       = 24;
  localparam int KEY_W       = 7;
  localparam int BW_W        = 16;
  localparam int SUM_W       = 32;
  localparam int FREQ_W      = 28;
  localparam int EDGE_W      = 16;
  localparam int EDGE_COUNT  = 129;
  localparam int EDGE_IW     = 8;
  localparam int MAX_BINS    = 4096;
  localparam int BIN_RANGE_W = 17;

  localparam logic [BW_W-1:0] BW_RESET = 16'd10;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_REQ,
    ST_RD_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_MUL,
    SR_STEP,
    SR_DONE
  } srch_state_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [KEY_W-1:0] key;
  } srch_rsp_t;

  // floor(440 * 2^((m - 48.5) / 12))
  localparam logic [EDGE_W-1:0] BAND_EDGE [EDGE_COUNT] = '{
    16'd26, 16'd28, 16'd29, 16'd31, 16'd33, 16'd35, 16'd37, 16'd40,
    16'd42, 16'd44, 16'd47, 16'd50, 16'd53, 16'd56, 16'd59, 16'd63,
    16'd67, 16'd71, 16'd75, 16'd80, 16'd84, 16'd89, 16'd95, 16'd100,
    16'd106, 16'd113, 16'd119, 16'd127, 16'd134, 16'd142, 16'd151, 16'd160,
    16'd169, 16'd179, 16'd190, 16'd201, 16'd213, 16'd226, 16'd239, 16'd254,
    16'd269, 16'd285, 16'd302, 16'd320, 16'd339, 16'd359, 16'd380, 16'd403,
    16'd427, 16'd452, 16'd479, 16'd508, 16'd538, 16'd570, 16'd604, 16'd640,
    16'd678, 16'd718, 16'd761, 16'd806, 16'd854, 16'd905, 16'd959, 16'd1016,
    16'd1077, 16'd1141, 16'd1209, 16'd1280, 16'd1357, 16'd1437, 16'd1523, 16'd1613,
    16'd1709, 16'd1811, 16'd1919, 16'd2033, 16'd2154, 16'd2282, 16'd2418, 16'd2561,
    16'd2714, 16'd2875, 16'd3046, 16'd3227, 16'd3419, 16'd3623, 16'd3838, 16'd4066,
    16'd4308, 16'd4564, 16'd4836, 16'd5123, 16'd5428, 16'd5751, 16'd6093, 16'd6455,
    16'd6839, 16'd7246, 16'd7677, 16'd8133, 16'd8617, 16'd9129, 16'd9672, 16'd10247,
    16'd10857, 16'd11502, 16'd12186, 16'd12911, 16'd13679, 16'd14492, 16'd15354,
    16'd16267, 16'd17234, 16'd18259, 16'd19345, 16'd20495, 16'd21714, 16'd23005,
    16'd24373, 16'd25822, 16'd27358, 16'd28985, 16'd30708, 16'd32534, 16'd34469,
    16'd36519, 16'd38690, 16'd40991, 16'd43428
  };

  function automatic logic [EDGE_W-1:0] band_edge(input logic [EDGE_IW-1:0] m);
    return (m < EDGE_IW'(EDGE_COUNT)) ? BAND_EDGE[m] : '1;
  endfunction

endpackage

// ===== rtl/spectrum_bin_to_piano_key_accumulator.sv =====
// Accumulate request: busy through the multiply, a search step per cycle, then a RAM
// read-write; the RAM read-write is skipped when no band matches.
// Read request: busy in RD_REQ and RD_OUT; strobe is registered from RD_OUT.
// One request at a time; the receiver cannot stall, each result shows for one cycle.
// Synchronous reset: per-key valid bits clear at once (all totals read as zero),
// bin_width_hz returns to 10; no clearing pass.
`include "assert_macros.svh"

module spectrum_bin_to_piano_key_accumulator import sbpk_pkg::*; #(
  parameter int KEY_COUNT = 88
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [BIN_W-1:0]  bin_index,
  input  logic [MAG_W-1:0]  magnitude,
  input  logic [KEY_W-1:0]  read_key,
  input  logic              cfg_we,
  input  logic [BW_W-1:0]   cfg_wdata,
  output logic              strobe,
  output logic [KEY_W-1:0]  key_number,
  output logic [SUM_W-1:0]  key_total
);

  localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  top_state_t       state;
  top_state_t       state_next;
  logic [BW_W-1:0]  bin_width_hz;
  logic [BIN_W-1:0] bin_q;
  logic [MAG_W-1:0] mag_q;
  logic [KEY_W-1:0] rkey_q;
  logic [AW-1:0]    acc_key;
  logic [KEY_COUNT-1:0] valid;

  logic             accept;
  logic             go_srch;
  srch_rsp_t        rsp;
  logic             rkey_in;
  logic [AW-1:0]    rkey_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_raddr;
  logic [SUM_W-1:0] mem_rdata;
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W:0]   raw_sum;
  logic [SUM_W-1:0] new_sum;

  assign accept    = start && !busy;
  assign rkey_in   = (KEY_W+1)'(rkey_q) < (KEY_W+1)'(KEY_COUNT);
  assign rkey_addr = rkey_q[AW-1:0];
  assign old_sum   = valid[acc_key] ? mem_rdata : '0;
  assign raw_sum   = {1'b0, old_sum} + (SUM_W+1)'(mag_q);
  assign new_sum   = raw_sum[SUM_W] ? '1 : raw_sum[SUM_W-1:0];

  sbpk_key_search #(
    .KEY_COUNT(KEY_COUNT)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .go          (go_srch),
    .bin_index   (bin_q),
    .bin_width_hz(bin_width_hz),
    .rsp         (rsp)
  );

  sbpk_ram #(
    .WIDTH(SUM_W),
    .DEPTH(KEY_COUNT)
  ) u_sums (
    .clk  (clk),
    .we   (mem_we),
    .waddr(acc_key),
    .wdata(new_sum),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (op == OP_READ) ? ST_RD_REQ : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (rsp.done) begin
          state_next = rsp.hit ? ST_ACC_RD : ST_IDLE;
        end
      end
      ST_ACC_RD: state_next = ST_ACC_WR;
      ST_ACC_WR: state_next = ST_IDLE;
      ST_RD_REQ: state_next = ST_RD_OUT;
      ST_RD_OUT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    go_srch   = (state == ST_IDLE) && start && (op == OP_ACC);
    mem_we    = (state == ST_ACC_WR);
    mem_raddr = (state == ST_RD_REQ) ? rkey_addr : acc_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bin_width_hz <= BW_RESET;
      valid        <= '0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_RD_OUT);
      if (cfg_we) begin
        bin_width_hz <= cfg_wdata;
      end
      if (state == ST_ACC_WR) begin
        valid[acc_key] <= 1'b1;
      end
      if (state == ST_RD_OUT && rkey_in) begin
        valid[rkey_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin_q  <= bin_index;
      mag_q  <= magnitude;
      rkey_q <= read_key;
    end
    if (state == ST_SEARCH && rsp.done) begin
      acc_key <= AW'(rsp.key);
    end
    if (state == ST_RD_OUT) begin
      key_number <= rkey_q;
      key_total  <= (rkey_in && valid[rkey_addr]) ? mem_rdata : '0;
    end
  end

  `SBPK_ASSERT_ALWAYS(a_rst_quiet, rst |=> !strobe && state == ST_IDLE)
  `SBPK_ASSERT(a_strobe_src, strobe |-> $past(state) == ST_RD_OUT)
  `SBPK_ASSERT(a_wr_after_rd, state == ST_ACC_WR |-> $past(state) == ST_ACC_RD)
  `SBPK_ASSERT(a_oob_zero, strobe && ((KEY_W+1)'(key_number) >= (KEY_W+1)'(KEY_COUNT)) |-> key_total == '0)

endmodule

// ===== rtl/sbpk_ram.sv =====
module sbpk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 88
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sbpk_key_search.sv =====
`include "assert_macros.svh"

module sbpk_key_search import sbpk_pkg::*; #(
  parameter int KEY_COUNT = 88
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [BIN_W-1:0]  bin_index,
  input  logic [BW_W-1:0]   bin_width_hz,
  output srch_rsp_t         rsp
);

  localparam int EW = $clog2(KEY_COUNT + 1);
  localparam logic [EW-1:0] KEY_LAST = EW'(KEY_COUNT);

  srch_state_t       state;
  srch_state_t       state_next;
  logic [FREQ_W-1:0] freq;
  logic [EW-1:0]     idx;
  logic [EW-1:0]     bitm;
  logic              low_ok;
  logic              in_rng;

  logic [FREQ_W-1:0] prod;
  logic [EW-1:0]     cand;
  logic              take;

  assign prod = FREQ_W'(bin_index) * FREQ_W'(bin_width_hz);
  assign cand = idx | bitm;
  assign take = (cand <= KEY_LAST) &&
                (FREQ_W'(band_edge(EDGE_IW'(cand))) < freq);

  always_comb begin
    state_next = state;
    case (state)
      SR_IDLE: begin
        if (go) begin
          state_next = SR_MUL;
        end
      end
      SR_MUL:  state_next = SR_STEP;
      SR_STEP: begin
        if (bitm[0]) begin
          state_next = SR_DONE;
        end
      end
      SR_DONE: state_next = SR_IDLE;
      default: state_next = SR_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == SR_DONE);
    rsp.hit  = in_rng && low_ok && (idx != KEY_LAST);
    rsp.key  = KEY_W'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SR_MUL: begin
        freq   <= prod;
        in_rng <= BIN_RANGE_W'(bin_index) < BIN_RANGE_W'(MAX_BINS);
        idx    <= '0;
        bitm   <= {1'b1, {(EW-1){1'b0}}};
      end
      SR_STEP: begin
        low_ok <= FREQ_W'(band_edge('0)) < freq;
        if (take) begin
          idx <= cand;
        end
        bitm <= bitm >> 1;
      end
      default: begin
      end
    endcase
  end

  `SBPK_ASSERT(a_mask_onehot, state == SR_STEP |-> $onehot(bitm))
  `SBPK_ASSERT(a_hit_in_range, rsp.done && rsp.hit |-> (KEY_W+1)'(rsp.key) < (KEY_W+1)'(KEY_COUNT))
  `SBPK_ASSERT(a_done_pulse, state == SR_DONE |=> state == SR_IDLE)

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import sbpk_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] total;
  } key_read_t;

  typedef struct packed {
    logic             op;
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    logic [KEY_W-1:0] key;
    logic             typed;
    logic [SUM_W-1:0] total;
  } dir_row_t;

  localparam int NUM_KEYS = 88;
  localparam int NUM_EDGES = 129;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // floored band edges in Hz; key k owns (edge[k], edge[k+1]]
  localparam int unsigned KEY_EDGE_HZ [NUM_EDGES] = '{
    26, 28, 29, 31, 33, 35, 37, 40, 42, 44, 47, 50,
    53, 56, 59, 63, 67, 71, 75, 80, 84, 89, 95, 100,
    106, 113, 119, 127, 134, 142, 151, 160, 169, 179, 190, 201,
    213, 226, 239, 254, 269, 285, 302, 320, 339, 359, 380, 403,
    427, 452, 479, 508, 538, 570, 604, 640, 678, 718, 761, 806,
    854, 905, 959, 1016, 1077, 1141, 1209, 1280, 1357, 1437, 1523, 1613,
    1709, 1811, 1919, 2033, 2154, 2282, 2418, 2561, 2714, 2875, 3046, 3227,
    3419, 3623, 3838, 4066, 4308, 4564, 4836, 5123, 5428, 5751, 6093, 6455,
    6839, 7246, 7677, 8133, 8617, 9129, 9672, 10247, 10857, 11502, 12186, 12911,
    13679, 14492, 15354, 16267, 17234, 18259, 19345, 20495, 21714, 23005, 24373, 25822,
    27358, 28985, 30708, 32534, 34469, 36519, 38690, 40991, 43428
  };

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{OP_READ, 12'd0,    24'h000000, 7'd0,   1'b1, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd87,  1'b1, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd127, 1'b1, 32'd0},
    '{OP_ACC,  12'd0,    24'hFFFFFF, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd2,    24'hFFFFFF, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd3,    24'h000001, 7'd0,   1'b0, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd2,   1'b1, 32'd1},
    '{OP_ACC,  12'd4095, 24'hFFFFFF, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd430,  24'hFFFFFF, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd431,  24'h000005, 7'd0,   1'b0, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd87,  1'b1, 32'h00FFFFFF},
    '{OP_READ, 12'd0,    24'h000000, 7'd87,  1'b1, 32'd0},
    '{OP_ACC,  12'd44,   24'h000000, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd44,   24'hABCDEF, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd45,   24'h000100, 7'd0,   1'b0, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd48,  1'b0, 32'd0},
    '{OP_ACC,  12'd43,   24'h000001, 7'd0,   1'b0, 32'd0},
    '{OP_ACC,  12'd42,   24'h000002, 7'd0,   1'b0, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd47,  1'b0, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd88,  1'b1, 32'd0},
    '{OP_READ, 12'd0,    24'h000000, 7'd48,  1'b0, 32'd0}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             op = OP_ACC;
  logic [BIN_W-1:0] bin_index = '0;
  logic [MAG_W-1:0] magnitude = '0;
  logic [KEY_W-1:0] read_key = '0;
  logic             cfg_we = 1'b0;
  logic [BW_W-1:0]  cfg_wdata = '0;
  logic             strobe;
  logic [KEY_W-1:0] key_number;
  logic [SUM_W-1:0] key_total;

  logic [SUM_W-1:0] key_sum_mdl [NUM_KEYS];
  logic [BW_W-1:0]  bin_step_hz;
  key_read_t        key_read_q [$];
  int               mismatch_count = 0;
  int               sender_idle_pct = 0;

  spectrum_bin_to_piano_key_accumulator u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .bin_index  (bin_index),
    .magnitude  (magnitude),
    .read_key   (read_key),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .strobe     (strobe),
    .key_number (key_number),
    .key_total  (key_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int key_of_freq(input logic [31:0] freq);
    int k;
    key_of_freq = -1;
    for (k = 0; k < NUM_KEYS; k++) begin
      if (freq > KEY_EDGE_HZ[k] && freq <= KEY_EDGE_HZ[k+1]) begin
        key_of_freq = k;
        break;
      end
    end
  endfunction

  function automatic void keybank_step(input logic op_v, input logic [BIN_W-1:0] bin_v,
                                       input logic [MAG_W-1:0] mag_v,
                                       input logic [KEY_W-1:0] key_v,
                                       output logic has_read, output key_read_t rd);
    logic [31:0]      freq;
    logic [SUM_W:0]   acc;
    int               k;
    has_read = 1'b0;
    rd = '0;
    if (op_v == OP_ACC) begin
      freq = 32'(bin_v) * 32'(bin_step_hz);
      k = key_of_freq(freq);
      if (k >= 0) begin
        acc = {1'b0, key_sum_mdl[k]} + (SUM_W+1)'(mag_v);
        key_sum_mdl[k] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      end
    end else begin
      has_read = 1'b1;
      rd.key = key_v;
      if (key_v < NUM_KEYS) begin
        rd.total = key_sum_mdl[key_v];
        key_sum_mdl[key_v] = '0;
      end
    end
  endfunction

  // start stays high from the previous request unless a gap is taken
  task automatic issue(input logic op_v, input logic [BIN_W-1:0] bin_v,
                       input logic [MAG_W-1:0] mag_v, input logic [KEY_W-1:0] key_v,
                       input logic typed, input logic [SUM_W-1:0] typed_total);
    int        gap;
    logic      has_read;
    key_read_t rd;
    gap = 0;
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= op_v;
    bin_index <= bin_v;
    magnitude <= mag_v;
    read_key <= key_v;
    do @(posedge clk); while (busy);
    keybank_step(op_v, bin_v, mag_v, key_v, has_read, rd);
    if (has_read) begin
      if (typed) rd.total = typed_total;
      key_read_q.push_back(rd);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (key_read_q.size() != 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_bin_width(input logic [BW_W-1:0] bw);
    cfg_we <= 1'b1;
    cfg_wdata <= bw;
    @(posedge clk);
    cfg_we <= 1'b0;
    bin_step_hz = bw;
  endtask

  task automatic run_phase(input logic [BW_W-1:0] bw, input int n_req, input int idle_pct);
    int               lo;
    int               hi;
    int               hot;
    int               sel;
    int               t;
    int               i;
    logic             op_v;
    logic [BIN_W-1:0] bin_v;
    logic [MAG_W-1:0] mag_v;
    logic [KEY_W-1:0] key_v;
    settle();
    write_bin_width(bw);
    sender_idle_pct = idle_pct;
    if (bw != 0) begin
      lo = 26 / bw + 1;
      hi = 4308 / bw;
      if (hi > 4095) hi = 4095;
    end else begin
      lo = 1;
      hi = 0;
    end
    if (lo > hi) begin
      lo = 0;
      hi = 4095;
    end
    hot = $urandom_range(hi, lo);
    for (i = 0; i < n_req; i++) begin
      bin_v = BIN_W'($urandom);
      mag_v = MAG_W'($urandom);
      key_v = KEY_W'($urandom);
      if ($urandom_range(0, 99) < 12) begin
        op_v = OP_READ;
        if ($urandom_range(0, 9) < 7) key_v = KEY_W'($urandom_range(0, NUM_KEYS - 1));
      end else begin
        op_v = OP_ACC;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          bin_v = BIN_W'(hot);
          if ($urandom_range(0, 9) < 9) mag_v = MAG_MAX;
        end else if (sel < 88 && bw != 0) begin
          // land on or just past a band edge
          t = KEY_EDGE_HZ[$urandom_range(0, NUM_KEYS)] / bw + $urandom_range(0, 1);
          if (t <= 4095) bin_v = BIN_W'(t);
        end else if (sel < 95) begin
          bin_v = BIN_W'($urandom_range(hi, lo));
        end
      end
      issue(op_v, bin_v, mag_v, key_v, 1'b0, '0);
    end
    for (i = 0; i < 128; i++) begin
      issue(OP_READ, BIN_W'($urandom), MAG_W'($urandom), KEY_W'(i), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_reads
    key_read_t exp_r;
    if (!rst && strobe) begin
      if (key_read_q.size() == 0) begin
        $error("unexpected read result: key_number=%0d key_total=0x%0h",
               key_number, key_total);
        mismatch_count++;
      end else begin
        exp_r = key_read_q.pop_front();
        if (key_number !== exp_r.key) begin
          $error("key_number: expected %0d, got %0d", exp_r.key, key_number);
          mismatch_count++;
        end
        if (key_total !== exp_r.total) begin
          $error("key_total: expected 0x%0h, got 0x%0h", exp_r.total, key_total);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stim
    int i;
    for (i = 0; i < NUM_KEYS; i++) key_sum_mdl[i] = '0;
    bin_step_hz = BW_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 0;
    for (i = 0; i < DIR_ROWS; i++) begin
      issue(DIR_TABLE[i].op, DIR_TABLE[i].bin, DIR_TABLE[i].mag, DIR_TABLE[i].key,
            DIR_TABLE[i].typed, DIR_TABLE[i].total);
    end

    run_phase(16'd1, 200, 0);
    run_phase(16'hFFFF, 40, 83);
    run_phase(16'd10, 200, 83);
    run_phase(16'd0, 40, 26);
    run_phase(BW_W'($urandom_range(40, 2)), 200, 26);
    run_phase(BW_W'($urandom_range(65535, 0)), 40, 0);
    run_phase(16'd7, 180, 0);

    start <= 1'b0;
    @(posedge clk);
    while (key_read_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
